[rtl/core/sosg_pkg.sv]
// shared types, opcodes and helpers for the sparse one-site gate block
package sosg_pkg;

    localparam logic [1:0] OP_GATE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 80;

    typedef enum logic [1:0] {
        CMD_GATE,
        CMD_LOAD,
        CMD_FETCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [14:0]        basis;
        logic signed [31:0] val_re;
        logic signed [31:0] val_im;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic init_done;
    } back_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            r = v[31:0];
        end else if (v[35]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

[rtl/core/sparse_one_site_gate.sv]
// top level of the sparse one-site gate block
// Input stream s_*: tuser carries the opcode (write gate element, load state
// entry, fetch result; code 3 is dropped), tlast marks the final state entry,
// tdata carries row, column, basis and the complex Q2.30 value.
// Output stream m_*: one item per fetch; tdata holds basis and the complex
// amplitude, tuser is 1 for a returned entry and 0 once none remain.
// A four-deep command queue sits between the input side and the executor,
// so input is taken while the executor works or a result waits.
// Sequence: a gate write is done in the executor's idle state; a load
// runs, per level, the serial gate read, multiply, table lookup and
// update (only the gate read for a zero gate element); a fetch skips
// zero entries one by one (none while loading), then its result passes
// into the output register.
// After reset the slot index ram is cleared, one entry per cycle over all
// PHYS_DIM*BOND_SPACE entries, with s_tready low.
// A stalled receiver holds the output register; the executor then waits
// and the queue fills before s_tready drops.
module sparse_one_site_gate #(
    parameter int PHYS_DIM    = 6,
    parameter int BOND_SPACE  = 4096,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row[2:0], col[5:3], basis[20:6], value_re[52:21], value_im[84:53]
    input  logic [sosg_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_basis[14:0], out_re[46:15], out_im[78:47]
    output logic [sosg_pkg::M_DATA_W-1:0] m_tdata,
    // out_valid[0]
    output logic                          m_tuser
);
    import sosg_pkg::*;

    logic       q_valid;
    cmd_t       q_cmd;
    back_stat_t stat;

    sosg_front #(.PHYS_DIM(PHYS_DIM)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .q_valid, .q_cmd, .stat
    );

    sosg_back #(
        .PHYS_DIM(PHYS_DIM), .BOND_SPACE(BOND_SPACE), .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_cmd, .stat,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );
endmodule

[rtl/core/sosg_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module sosg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/sosg_front.sv]
// input side: accepts items, drops no-ops and out-of-range gate writes, queues decoded commands
module sosg_front #(
    parameter int PHYS_DIM = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sosg_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            q_valid,
    output sosg_pkg::cmd_t                  q_cmd,
    input  sosg_pkg::back_stat_t            stat
);
    import sosg_pkg::*;

    localparam int QD = 4;

    cmd_t       q_mem [QD];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] fill_reg;
    logic       full;
    logic       keep;
    logic       push;
    cmd_t       cmd_in;

    assign full     = (fill_reg == 3'(QD));
    assign s_tready = !full && stat.init_done;
    assign q_valid  = (fill_reg != 3'd0);
    assign q_cmd    = q_mem[rd_ptr_reg];

    always_comb begin
        cmd_in.row    = s_tdata[2:0];
        cmd_in.col    = s_tdata[5:3];
        cmd_in.basis  = s_tdata[20:6];
        cmd_in.val_re = s_tdata[52:21];
        cmd_in.val_im = s_tdata[84:53];
        cmd_in.last   = s_tlast;
        cmd_in.kind   = CMD_FETCH;
        keep          = 1'b0;
        case (s_tuser)
            OP_GATE: begin
                cmd_in.kind = CMD_GATE;
                // writes outside the matrix are ignored
                keep = (32'(s_tdata[2:0]) < PHYS_DIM) && (32'(s_tdata[5:3]) < PHYS_DIM);
            end
            OP_LOAD: begin
                cmd_in.kind = CMD_LOAD;
                keep        = 1'b1;
            end
            OP_FETCH: begin
                cmd_in.kind = CMD_FETCH;
                keep        = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                q_mem[wr_ptr_reg] <= cmd_in;
                wr_ptr_reg        <= wr_ptr_reg + 2'd1;
            end
            if (stat.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + 3'(push) - 3'(stat.pop);
        end
    end
endmodule

[rtl/core/sosg_back.sv]
// execution side: gate store, accumulator table, drain and result register
module sosg_back #(
    parameter int PHYS_DIM    = 6,
    parameter int BOND_SPACE  = 4096,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  sosg_pkg::cmd_t                q_cmd,
    output sosg_pkg::back_stat_t          stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sosg_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import sosg_pkg::*;

    localparam int TBL_D  = PHYS_DIM * BOND_SPACE;
    localparam int TBL_AW = $clog2(TBL_D);
    localparam int CNT_W  = $clog2(TBL_D + 1);
    localparam int GATE_D = PHYS_DIM * PHYS_DIM;
    localparam int GA_W   = $clog2(GATE_D);
    localparam int LVL_W  = $clog2(PHYS_DIM + 1);
    localparam int EM_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ACC_W  = TBL_AW + 64;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_GADR, S_GCHK, S_SUM, S_SADR, S_SLOT, S_ACC,
        S_DADR, S_DCHK, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [TBL_AW-1:0]   clr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [EM_W-1:0]     emit_reg;
    logic                draining_reg;
    logic [LVL_W-1:0]    k_reg;
    logic [LVL_W-1:0]    kold_reg;
    logic [31:0]         bond_reg;
    logic signed [31:0]  ar_reg, ai_reg;
    logic                last_reg;
    logic signed [63:0]  prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [34:0]  pr_reg, pi_reg;
    logic [TBL_AW-1:0]   nb_reg;
    logic [TBL_AW-1:0]   s_reg;
    logic [14:0]         res_basis_reg;
    logic signed [31:0]  res_re_reg, res_im_reg;
    logic                res_valid_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_user_reg;

    logic [LVL_W-1:0]    level_dec;
    logic [31:0]         bond_dec;
    logic                gate_we;
    logic [GA_W-1:0]     gate_waddr, gate_raddr;
    logic [63:0]         gate_rdata;
    logic                slot_we;
    logic [TBL_AW-1:0]   slot_waddr, slot_wdata, slot_rdata;
    logic                acc_we;
    logic [TBL_AW-1:0]   acc_waddr, acc_raddr;
    logic [ACC_W-1:0]    acc_wdata, acc_rdata;
    logic signed [31:0]  g_re, g_im, a_re, a_im;
    logic                hit, room;
    logic signed [31:0]  new_re, new_im;
    logic signed [64:0]  sum_r, sum_i;
    logic [CNT_W-1:0]    pos_inc;
    logic                out_free;

    // level is the number of level boundaries at or below the basis
    always_comb begin
        level_dec = '0;
        for (int j = 1; j <= PHYS_DIM; j++) begin
            if (32'(q_cmd.basis) >= 32'(j * BOND_SPACE)) begin
                level_dec = level_dec + LVL_W'(1);
            end
        end
        bond_dec = 32'(q_cmd.basis) - 32'(level_dec) * 32'(BOND_SPACE);
    end

    assign g_re = gate_rdata[31:0];
    assign g_im = gate_rdata[63:32];
    assign a_re = acc_rdata[31:0];
    assign a_im = acc_rdata[63:32];

    assign hit  = ({1'b0, s_reg} < count_reg) && (acc_rdata[ACC_W-1:64] == nb_reg);
    assign room = count_reg < CNT_W'(TBL_D);

    always_comb begin
        if (hit) begin
            new_re = sat32(36'(a_re) + 36'(pr_reg));
            new_im = sat32(36'(a_im) + 36'(pi_reg));
        end else begin
            new_re = sat32(36'(pr_reg));
            new_im = sat32(36'(pi_reg));
        end
    end

    assign sum_r   = 65'(prr_reg) - 65'(pii_reg);
    assign sum_i   = 65'(pri_reg) + 65'(pir_reg);
    assign pos_inc = pos_reg + CNT_W'(1);

    assign gate_we    = (state_reg == S_IDLE) && q_valid && (q_cmd.kind == CMD_GATE);
    assign gate_waddr = GA_W'(32'(q_cmd.row) * 32'(PHYS_DIM) + 32'(q_cmd.col));
    assign gate_raddr = GA_W'(32'(k_reg) * 32'(PHYS_DIM) + 32'(kold_reg));

    assign slot_we    = (state_reg == S_CLEAR) || ((state_reg == S_ACC) && !hit && room);
    assign slot_waddr = (state_reg == S_CLEAR) ? clr_reg : nb_reg;
    assign slot_wdata = (state_reg == S_CLEAR) ? '0 : count_reg[TBL_AW-1:0];

    assign acc_we    = (state_reg == S_ACC) && (hit || room);
    assign acc_waddr = hit ? s_reg : count_reg[TBL_AW-1:0];
    assign acc_wdata = {nb_reg, new_im, new_re};
    assign acc_raddr = (state_reg == S_SLOT) ? slot_rdata : pos_reg[TBL_AW-1:0];

    assign stat.pop       = (state_reg == S_IDLE) && q_valid;
    assign stat.init_done = (state_reg != S_CLEAR);

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    sosg_ram #(.WIDTH(64), .DEPTH(GATE_D)) u_gate (
        .clk(aclk), .we(gate_we), .waddr(gate_waddr),
        .wdata({q_cmd.val_im, q_cmd.val_re}), .raddr(gate_raddr), .rdata(gate_rdata)
    );

    sosg_ram #(.WIDTH(TBL_AW), .DEPTH(TBL_D)) u_slot (
        .clk(aclk), .we(slot_we), .waddr(slot_waddr),
        .wdata(slot_wdata), .raddr(nb_reg), .rdata(slot_rdata)
    );

    sosg_ram #(.WIDTH(ACC_W), .DEPTH(TBL_D)) u_acc (
        .clk(aclk), .we(acc_we), .waddr(acc_waddr),
        .wdata(acc_wdata), .raddr(acc_raddr), .rdata(acc_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            emit_reg     <= '0;
            draining_reg <= 1'b0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + TBL_AW'(1);
                    if (32'(clr_reg) == TBL_D - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        case (q_cmd.kind)
                            CMD_LOAD: begin
                                if (draining_reg) begin
                                    count_reg    <= '0;
                                    draining_reg <= 1'b0;
                                end
                                kold_reg <= level_dec;
                                bond_reg <= bond_dec;
                                ar_reg   <= q_cmd.val_re;
                                ai_reg   <= q_cmd.val_im;
                                last_reg <= q_cmd.last;
                                k_reg    <= '0;
                                if (32'(level_dec) < PHYS_DIM) begin
                                    state_reg <= S_GADR;
                                end else if (q_cmd.last) begin
                                    draining_reg <= 1'b1;
                                    pos_reg      <= '0;
                                    emit_reg     <= '0;
                                end
                            end
                            CMD_FETCH: begin
                                res_basis_reg <= '0;
                                res_re_reg    <= '0;
                                res_im_reg    <= '0;
                                res_valid_reg <= 1'b0;
                                if (!draining_reg) begin
                                    state_reg <= S_EMIT;
                                end else if (pos_reg >= count_reg ||
                                             32'(emit_reg) >= MAX_ENTRIES) begin
                                    count_reg    <= '0;
                                    pos_reg      <= '0;
                                    emit_reg     <= '0;
                                    draining_reg <= 1'b0;
                                    state_reg    <= S_EMIT;
                                end else begin
                                    state_reg <= S_DADR;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_GADR: begin
                    state_reg <= S_GCHK;
                end
                S_GCHK: begin
                    prr_reg <= g_re * ar_reg;
                    pii_reg <= g_im * ai_reg;
                    pri_reg <= g_re * ai_reg;
                    pir_reg <= g_im * ar_reg;
                    nb_reg  <= TBL_AW'(32'(k_reg) * 32'(BOND_SPACE) + bond_reg);
                    // zero gate elements add nothing
                    if (g_re == 32'sd0 && g_im == 32'sd0) begin
                        if (32'(k_reg) == PHYS_DIM - 1) begin
                            state_reg <= S_IDLE;
                            if (last_reg) begin
                                draining_reg <= 1'b1;
                                pos_reg      <= '0;
                                emit_reg     <= '0;
                            end
                        end else begin
                            k_reg     <= k_reg + LVL_W'(1);
                            state_reg <= S_GADR;
                        end
                    end else begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    pr_reg    <= sum_r[64:30];
                    pi_reg    <= sum_i[64:30];
                    state_reg <= S_SADR;
                end
                S_SADR: begin
                    state_reg <= S_SLOT;
                end
                S_SLOT: begin
                    s_reg     <= slot_rdata;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    if (!hit && room) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (32'(k_reg) == PHYS_DIM - 1) begin
                        state_reg <= S_IDLE;
                        if (last_reg) begin
                            draining_reg <= 1'b1;
                            pos_reg      <= '0;
                            emit_reg     <= '0;
                        end
                    end else begin
                        k_reg     <= k_reg + LVL_W'(1);
                        state_reg <= S_GADR;
                    end
                end
                S_DADR: begin
                    state_reg <= S_DCHK;
                end
                S_DCHK: begin
                    pos_reg <= pos_inc;
                    if (a_re == 32'sd0 && a_im == 32'sd0) begin
                        // skip entries that cancelled to zero
                        if (pos_inc >= count_reg) begin
                            count_reg    <= '0;
                            pos_reg      <= '0;
                            emit_reg     <= '0;
                            draining_reg <= 1'b0;
                            state_reg    <= S_EMIT;
                        end else begin
                            state_reg <= S_DADR;
                        end
                    end else begin
                        res_basis_reg <= 15'(acc_rdata[ACC_W-1:64]);
                        res_re_reg    <= a_re;
                        res_im_reg    <= a_im;
                        res_valid_reg <= 1'b1;
                        emit_reg      <= emit_reg + EM_W'(1);
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_data_reg  <= {1'b0, res_im_reg, res_re_reg, res_basis_reg};
                        m_user_reg  <= res_valid_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[sim/sosg_checker.sv]
// stream monitor, gate predictor and result comparison for the sparse one-site gate block
module sosg_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sosg_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sosg_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sosg_pkg::*;

    localparam int NLEV  = 6;
    localparam int BONDS = 4096;
    localparam int CAP   = 4096;

    typedef struct {
        logic [14:0]        basis;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               found;
    } fetch_result_t;

    logic signed [31:0] gate_re [NLEV*NLEV];
    logic signed [31:0] gate_im [NLEV*NLEV];
    int                 slot_by_basis [int];
    logic [14:0]        amp_basis [$];
    logic signed [31:0] amp_re [$];
    logic signed [31:0] amp_im [$];
    int                 drain_pos;
    int                 emitted;
    bit                 draining;
    fetch_result_t      fetch_q [$];

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fff_ffff;
        if (v < -66'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void clear_amps();
        amp_basis.delete();
        amp_re.delete();
        amp_im.delete();
        slot_by_basis.delete();
        drain_pos = 0;
        emitted   = 0;
        draining  = 0;
    endfunction

    function automatic void add_term(input int nb, input logic signed [65:0] pr,
                                     input logic signed [65:0] pi);
        int s;
        if (slot_by_basis.exists(nb)) begin
            s = slot_by_basis[nb];
            amp_re[s] = clamp32(66'(amp_re[s]) + pr);
            amp_im[s] = clamp32(66'(amp_im[s]) + pi);
        end else begin
            slot_by_basis[nb] = amp_basis.size();
            amp_basis.push_back(15'(nb));
            amp_re.push_back(clamp32(pr));
            amp_im.push_back(clamp32(pi));
        end
    endfunction

    function automatic void apply_gate(input logic [14:0] b, input logic signed [31:0] ar,
                                       input logic signed [31:0] ai, input logic last);
        int lev;
        int bond;
        logic signed [65:0] ur, ui, xr, xi, pr, pi;
        lev  = int'(b) / BONDS;
        bond = int'(b) % BONDS;
        if (draining) clear_amps();
        if (lev < NLEV) begin
            xr = ar;
            xi = ai;
            for (int k = 0; k < NLEV; k++) begin
                ur = gate_re[k*NLEV + lev];
                ui = gate_im[k*NLEV + lev];
                if (ur != 0 || ui != 0) begin
                    pr = (ur*xr - ui*xi) >>> 30;
                    pi = (ur*xi + ui*xr) >>> 30;
                    add_term(k*BONDS + bond, pr, pi);
                end
            end
        end
        if (last) begin
            draining  = 1;
            drain_pos = 0;
            emitted   = 0;
        end
    endfunction

    function automatic fetch_result_t next_amp();
        fetch_result_t r;
        r = '{basis: '0, re: '0, im: '0, found: 1'b0};
        if (!draining) return r;
        while (drain_pos < amp_basis.size() &&
               amp_re[drain_pos] == 0 && amp_im[drain_pos] == 0)
            drain_pos++;
        if (drain_pos < amp_basis.size() && emitted < CAP) begin
            r = '{basis: amp_basis[drain_pos], re: amp_re[drain_pos],
                  im: amp_im[drain_pos], found: 1'b1};
            drain_pos++;
            emitted++;
        end else begin
            clear_amps();
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        fetch_result_t want;
        logic [2:0] row;
        logic [2:0] col;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
            clear_amps();
            fetch_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (fetch_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result item: basis %0d re %0d im %0d valid %0b",
                                 m_tdata[14:0], $signed(m_tdata[46:15]),
                                 $signed(m_tdata[78:47]), m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = fetch_q.pop_front();
                    if (m_tdata[14:0] !== want.basis || m_tdata[46:15] !== want.re ||
                        m_tdata[78:47] !== want.im || m_tuser !== want.found) begin
                        if (fail_count < 10) begin
                            $write("mismatch: expected basis %0d re %0d im %0d valid %0b",
                                   want.basis, want.re, want.im, want.found);
                            $display(", got basis %0d re %0d im %0d valid %0b",
                                     m_tdata[14:0], $signed(m_tdata[46:15]),
                                     $signed(m_tdata[78:47]), m_tuser);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                row = s_tdata[2:0];
                col = s_tdata[5:3];
                case (s_tuser)
                    OP_GATE: begin
                        if (row < NLEV && col < NLEV) begin
                            gate_re[row*NLEV + col] = s_tdata[52:21];
                            gate_im[row*NLEV + col] = s_tdata[84:53];
                        end
                    end
                    OP_LOAD: apply_gate(s_tdata[20:6], s_tdata[52:21], s_tdata[84:53], s_tlast);
                    OP_FETCH: fetch_q.push_back(next_amp());
                    default: ;
                endcase
            end
            pending <= fetch_q.size();
        end
    end
endmodule

[sim/tb.sv]
// stimulus and verdict for the sparse one-site gate block
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sosg_pkg::*;

    localparam int LIMIT = 2000000;
    localparam logic [1:0] OP_NOP = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = OP_NOP;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    int                  sent = 0;
    bit                  quiet = 0;
    bit                  hold_req = 0;
    bit                  hold_done = 0;
    int                  hold_left = 0;

    sparse_one_site_gate DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sosg_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAIL sparse_one_site_gate");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    task automatic put_item(input logic [1:0] op, input logic [2:0] row, input logic [2:0] col,
                            input logic [14:0] b, input logic [31:0] re,
                            input logic [31:0] im, input logic last);
        if (!quiet && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b000, im, re, b, col, row};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // step past the last item sent so the checker's count includes it
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h4000_0000;
            4: return 32'hc000_0000;
            5, 6: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h7fff_ffff))
                                >>> $urandom_range(1, 8))
                            ^ {32{1'($urandom_range(1))}};
        endcase
    endfunction

    task automatic fetch_n(input int n);
        for (int i = 0; i < n; i++)
            put_item(OP_FETCH, 3'($urandom), 3'($urandom), 15'($urandom), $urandom,
                     $urandom, 1'($urandom));
    endtask

    task automatic load_one(input logic [14:0] b, input logic [31:0] re, input logic [31:0] im,
                            input logic last);
        put_item(OP_LOAD, 3'($urandom), 3'($urandom), b, re, im, last);
    endtask

    initial begin
        int n;
        int base;
        int lev;
        int nf;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every gate element gets written before any load reads it
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 6; c++)
                put_item(OP_GATE, 3'(r), 3'(c), 15'($urandom),
                         (r == c) ? 32'h7fff_ffff : ((r + c) % 3 == 0 ? 32'h0 : pick_value()),
                         (r == c) ? 32'h0 : ((r + c) % 3 == 0 ? 32'h0 : pick_value()), 1'b0);
        put_item(OP_GATE, 3'd6, 3'd1, 15'($urandom), $urandom, $urandom, 1'b0);
        put_item(OP_GATE, 3'd2, 3'd7, 15'($urandom), $urandom, $urandom, 1'b0);
        fetch_n(1);
        put_item(OP_NOP, 3'($urandom), 3'($urandom), 15'($urandom), $urandom, $urandom, 1'b1);
        load_one(15'd5, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        load_one(15'd5, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        load_one(15'd20480 + 15'd4095, 32'h8000_0000, 32'h8000_0000, 1'b0);
        load_one(15'd24576, 32'h7fff_ffff, 32'h1, 1'b0);
        load_one(15'h7fff, 32'h1, 32'h1, 1'b1);
        fetch_n(3);
        // load while draining throws away what is left
        load_one(15'd4096, 32'h4000_0000, 32'h0, 1'b1);
        fetch_n(10);
        load_one(15'd28000, 32'h1234_5678, 32'h1, 1'b1);
        fetch_n(2);
        drain_wait();

        // long run with no idling: column 0 all nonzero
        for (int r = 0; r < 6; r++)
            put_item(OP_GATE, 3'(r), 3'd0, 15'($urandom), 32'h1000_0000, 32'(r), 1'b0);
        quiet = 1;
        for (int i = 0; i < 60; i++)
            load_one(15'(i), 32'h4000_0000, 32'hf000_0000, i == 59);
        fetch_n(362);
        quiet = 0;
        drain_wait();

        for (int seq = 0; sent < 1350; seq++) begin
            quiet = (seq >= 8 && seq < 14);
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(99) < 80)
                        put_item(OP_GATE, 3'($urandom_range(5)), 3'($urandom_range(5)),
                                 15'($urandom),
                                 $urandom_range(2) == 0 ? 32'h0 : pick_value(),
                                 $urandom_range(2) == 0 ? 32'h0 : pick_value(),
                                 1'($urandom));
                    else
                        put_item(OP_GATE, 3'($urandom), 3'($urandom), 15'($urandom),
                                 $urandom, $urandom, 1'($urandom));
                end
            end
            n = $urandom_range(1, 10);
            base = $urandom_range(0, 4095);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(99) < 5) fetch_n(1);
                if ($urandom_range(99) < 5)
                    put_item(OP_NOP, 3'($urandom), 3'($urandom), 15'($urandom), $urandom,
                             $urandom, 1'($urandom));
                lev = ($urandom_range(99) < 90) ? $urandom_range(5) : $urandom_range(6, 7);
                load_one(15'(lev * 4096 + (base + $urandom_range(3)) % 4096),
                         pick_value(), pick_value(), i == n - 1);
            end
            nf = ($urandom_range(99) < 15) ? $urandom_range(0, n) : n * 6 + 2;
            if (seq == 4) begin
                nf = 60;
                hold_req = 1;
            end
            fetch_n(nf);
            if ($urandom_range(99) < 10) drain_wait();
        end

        drain_wait();
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS sparse_one_site_gate");
        end else begin
            $display("FAIL sparse_one_site_gate");
        end
        $finish;
    end
endmodule
